FILE: hdl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// types and constants shared by the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned NumElem = 9;
  localparam int unsigned ElemW   = 32;
  localparam int unsigned CofW    = 64;
  localparam int unsigned DetW    = 97;
  localparam int unsigned MagW    = 96;
  localparam int unsigned QuotW   = 32;

  // cofactor i = a[x]*a[y] - a[z]*a[w], a indexed row*3 + column
  localparam int unsigned CofIdx [NumElem][4] = '{
    '{4, 8, 5, 7}, '{7, 2, 8, 1}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{8, 0, 6, 2}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{6, 1, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic signed [ElemW-1:0] m00;
    logic signed [ElemW-1:0] m01;
    logic signed [ElemW-1:0] m02;
    logic signed [ElemW-1:0] m10;
    logic signed [ElemW-1:0] m11;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m20;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [ElemW-1:0] r00;
    logic signed [ElemW-1:0] r01;
    logic signed [ElemW-1:0] r02;
    logic signed [ElemW-1:0] r10;
    logic signed [ElemW-1:0] r11;
    logic signed [ElemW-1:0] r12;
    logic signed [ElemW-1:0] r20;
    logic signed [ElemW-1:0] r21;
    logic signed [ElemW-1:0] r22;
    logic                    near_singular;
    logic                    clipped;
  } res_t;

  typedef logic [NumElem-1:0][CofW-1:0] cof_vec_t;
  typedef logic [2:0][ElemW-1:0]        row_t;

  typedef struct packed {
    logic [MagW-1:0] dmag;
    logic            dneg;
    logic            sing;
  } det_info_t;

endpackage

FILE: hdl/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// two stages: eighteen 32x32 products, then the nine cofactor differences
// ----------------------------------------------------------------------------
module mi3_cofactor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mi3_pkg::mat_t       mat_i,
  output logic                valid_o,
  output mi3_pkg::cof_vec_t   cof_o,
  output mi3_pkg::row_t       row_o
);

  logic signed [mi3_pkg::ElemW-1:0] a [mi3_pkg::NumElem];
  logic signed [mi3_pkg::CofW-1:0]  pa_d [mi3_pkg::NumElem];
  logic signed [mi3_pkg::CofW-1:0]  pb_d [mi3_pkg::NumElem];
  logic signed [mi3_pkg::CofW-1:0]  pa_q [mi3_pkg::NumElem];
  logic signed [mi3_pkg::CofW-1:0]  pb_q [mi3_pkg::NumElem];
  mi3_pkg::cof_vec_t                cof_d, cof_q;
  mi3_pkg::row_t                    row1_q, row2_q;
  logic                             v1_q, v2_q;

  always_comb begin
    a[0] = mat_i.m00;
    a[1] = mat_i.m01;
    a[2] = mat_i.m02;
    a[3] = mat_i.m10;
    a[4] = mat_i.m11;
    a[5] = mat_i.m12;
    a[6] = mat_i.m20;
    a[7] = mat_i.m21;
    a[8] = mat_i.m22;
    for (int i = 0; i < mi3_pkg::NumElem; i++) begin
      pa_d[i] = a[mi3_pkg::CofIdx[i][0]] * a[mi3_pkg::CofIdx[i][1]];
      pb_d[i] = a[mi3_pkg::CofIdx[i][2]] * a[mi3_pkg::CofIdx[i][3]];
    end
  end

  always_comb begin
    for (int i = 0; i < mi3_pkg::NumElem; i++) begin
      cof_d[i] = pa_q[i] - pb_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      row1_q <= {mat_i.m02, mat_i.m01, mat_i.m00};
      cof_q  <= cof_d;
      row2_q <= row1_q;
    end
  end

  assign valid_o = v2_q;
  assign cof_o   = cof_q;
  assign row_o   = row2_q;

endmodule

FILE: hdl/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// four stages: split 32x64 partial products, terms, determinant sum,
// magnitude with zero clamp and cofactor magnitudes
// ----------------------------------------------------------------------------
module mi3_det (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mi3_pkg::cof_vec_t   cof_i,
  input  mi3_pkg::row_t       row_i,
  output logic                valid_o,
  output mi3_pkg::det_info_t  info_o,
  output mi3_pkg::cof_vec_t   mag_o,
  output logic [mi3_pkg::NumElem-1:0] csign_o
);

  localparam int unsigned DetCof [3] = '{0, 3, 6};

  logic signed [63:0]               ph_d [3];
  logic signed [64:0]               pl_d [3];
  logic signed [63:0]               ph_q [3];
  logic signed [64:0]               pl_q [3];
  logic signed [mi3_pkg::DetW-1:0]  t_d [3];
  logic signed [mi3_pkg::DetW-1:0]  t_q [3];
  logic signed [mi3_pkg::DetW-1:0]  det_d, det_q, det_neg;
  mi3_pkg::cof_vec_t                cof3_q, cof4_q, cof5_q, mag_d, mag_q;
  logic [mi3_pkg::NumElem-1:0]      csign_q;
  mi3_pkg::det_info_t               info_d, info_q;
  logic                             v3_q, v4_q, v5_q, v6_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ph_d[k] = $signed(row_i[k]) * $signed(cof_i[DetCof[k]][63:32]);
      pl_d[k] = $signed(row_i[k]) * $signed({1'b0, cof_i[DetCof[k]][31:0]});
    end
    for (int k = 0; k < 3; k++) begin
      t_d[k] = (mi3_pkg::DetW'(ph_q[k]) <<< 32) + mi3_pkg::DetW'(pl_q[k]);
    end
    det_d   = t_q[0] + t_q[1] + t_q[2];
    det_neg = -det_q;
    info_d.sing = (det_q == '0);
    info_d.dneg = det_q[mi3_pkg::DetW-1];
    if (info_d.sing) begin
      info_d.dmag = mi3_pkg::MagW'(1);
    end else if (info_d.dneg) begin
      info_d.dmag = det_neg[mi3_pkg::MagW-1:0];
    end else begin
      info_d.dmag = det_q[mi3_pkg::MagW-1:0];
    end
    for (int i = 0; i < mi3_pkg::NumElem; i++) begin
      mag_d[i] = cof5_q[i][mi3_pkg::CofW-1] ? -cof5_q[i] : cof5_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      cof3_q <= cof_i;
      t_q    <= t_d;
      cof4_q <= cof3_q;
      det_q  <= det_d;
      cof5_q <= cof4_q;
      info_q <= info_d;
      mag_q  <= mag_d;
      for (int i = 0; i < mi3_pkg::NumElem; i++) begin
        csign_q[i] <= cof5_q[i][mi3_pkg::CofW-1];
      end
    end
  end

  assign valid_o = v6_q;
  assign info_o  = info_q;
  assign mag_o   = mag_q;
  assign csign_o = csign_q;

endmodule

FILE: hdl/mi3_divider.sv
// ----------------------------------------------------------------------------
// mi3_divider
// nine restoring divider lanes, one quotient bit per stage, with an
// overflow check stage in front and a saturation stage at the end
// ----------------------------------------------------------------------------
module mi3_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  mi3_pkg::det_info_t          info_i,
  input  mi3_pkg::cof_vec_t           mag_i,
  input  logic [mi3_pkg::NumElem-1:0] csign_i,
  output logic                        valid_o,
  output mi3_pkg::res_t               res_o
);

  localparam int unsigned Steps = mi3_pkg::QuotW;

  logic [mi3_pkg::MagW-1:0]    rem_q  [Steps+1][mi3_pkg::NumElem];
  logic [mi3_pkg::QuotW-1:0]   quo_q  [Steps+1][mi3_pkg::NumElem];
  logic [mi3_pkg::MagW-1:0]    dmag_q [Steps+1];
  logic [mi3_pkg::NumElem-1:0] neg_q  [Steps+1];
  logic [mi3_pkg::NumElem-1:0] ovf_q  [Steps+1];
  logic                        sing_q [Steps+1];
  logic                        v_q    [Steps+1];

  logic signed [mi3_pkg::ElemW-1:0] r_d [mi3_pkg::NumElem];
  logic [mi3_pkg::NumElem-1:0]      sat_d;
  mi3_pkg::res_t                    res_d, res_q;
  logic                             vo_q;

  // overflow check: quotient reaches 2^32 exactly when |cof| >= |det|
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q[0] <= info_i.dmag;
      sing_q[0] <= info_i.sing;
      for (int i = 0; i < mi3_pkg::NumElem; i++) begin
        rem_q[0][i] <= mi3_pkg::MagW'(mag_i[i]);
        quo_q[0][i] <= '0;
        ovf_q[0][i] <= mi3_pkg::MagW'(mag_i[i]) >= info_i.dmag;
        neg_q[0][i] <= csign_i[i] ^ info_i.dneg;
      end
    end
  end

  for (genvar s = 1; s <= Steps; s++) begin : g_step
    logic [mi3_pkg::MagW:0]   sh  [mi3_pkg::NumElem];
    logic [mi3_pkg::MagW:0]   dif [mi3_pkg::NumElem];
    logic [mi3_pkg::NumElem-1:0] ge;

    always_comb begin
      for (int i = 0; i < mi3_pkg::NumElem; i++) begin
        sh[i]  = {rem_q[s-1][i], 1'b0};
        dif[i] = sh[i] - {1'b0, dmag_q[s-1]};
        ge[i]  = !dif[i][mi3_pkg::MagW];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dmag_q[s] <= dmag_q[s-1];
        sing_q[s] <= sing_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        for (int i = 0; i < mi3_pkg::NumElem; i++) begin
          rem_q[s][i] <= ge[i] ? dif[i][mi3_pkg::MagW-1:0] : sh[i][mi3_pkg::MagW-1:0];
          quo_q[s][i] <= {quo_q[s-1][i][mi3_pkg::QuotW-2:0], ge[i]};
        end
      end
    end
  end

  always_comb begin
    logic [mi3_pkg::QuotW-1:0] lim;
    logic [mi3_pkg::QuotW-1:0] v;
    lim = '0;
    v   = '0;
    for (int i = 0; i < mi3_pkg::NumElem; i++) begin
      lim      = neg_q[Steps][i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat_d[i] = ovf_q[Steps][i] || (quo_q[Steps][i] > lim);
      v        = sat_d[i] ? lim : quo_q[Steps][i];
      r_d[i]   = neg_q[Steps][i] ? $signed(-v) : $signed(v);
    end
    res_d.r00           = r_d[0];
    res_d.r01           = r_d[1];
    res_d.r02           = r_d[2];
    res_d.r10           = r_d[3];
    res_d.r11           = r_d[4];
    res_d.r12           = r_d[5];
    res_d.r20           = r_d[6];
    res_d.r21           = r_d[7];
    res_d.r22           = r_d[8];
    res_d.near_singular = sing_q[Steps];
    res_d.clipped       = |sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule

FILE: hdl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// adjugate inverse of a signed Q16.16 3x3 matrix, saturated Q16.16 result
// ----------------------------------------------------------------------------
//  channel  valid        stall        payload
//  in       in_valid_i   in_stall_o   in_data_i  (mat_t)
//  out      out_valid_o  out_stall_i  out_data_o (res_t)
//
//  one beat in per cycle while the output is not stalled
//  the pipeline is the 32 one-bit divider stages plus 8 product, sum, check and saturation stages
//  the whole pipeline holds while the output register is full and stalled
//  reset clears the valid bits only
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mi3_pkg::mat_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mi3_pkg::res_t  out_data_o
);

  logic                        en;
  logic                        cof_valid, det_valid;
  mi3_pkg::cof_vec_t           cof, mag;
  mi3_pkg::row_t               row;
  mi3_pkg::det_info_t          info;
  logic [mi3_pkg::NumElem-1:0] csign;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  mi3_cofactor u_cofactor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mat_i   (in_data_i),
    .valid_o (cof_valid),
    .cof_o   (cof),
    .row_o   (row)
  );

  mi3_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cof_valid),
    .cof_i   (cof),
    .row_i   (row),
    .valid_o (det_valid),
    .info_o  (info),
    .mag_o   (mag),
    .csign_o (csign)
  );

  mi3_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (det_valid),
    .info_i  (info),
    .mag_i   (mag),
    .csign_i (csign),
    .valid_o (out_valid_o),
    .res_o   (out_data_o)
  );

  // input held off only behind a stalled output beat
  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stall without stalled output");

  // singular beat: a nonzero r11 element implies the beat is clipped
  a_sing_clip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.near_singular && (out_data_o.r11 != '0))
      |-> out_data_o.clipped)
    else $error("singular nonzero element not clipped");

  // singular beat element r00 is zero or full scale
  a_sing_val : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.near_singular) |->
      (out_data_o.r00 == 32'sh0 || out_data_o.r00 == 32'sh7FFF_FFFF ||
       out_data_o.r00 == 32'sh8000_0000))
    else $error("singular element not saturated");

endmodule
